/* sv/bls_pkg.sv */
package bls_pkg;

    // Stack geometry
    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Fixed field widths
    localparam int WORD_W = 32;
    localparam int FUNC_W = 3;
    localparam int WC_W   = 5;

    typedef logic [FUNC_W-1:0]        func_t;
    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [WC_W-1:0]          wcount_t;

    // Operation codes; unused codes act as a query
    localparam func_t FN_QUERY   = 3'd0;
    localparam func_t FN_PUSH    = 3'd1;
    localparam func_t FN_POP     = 3'd2;
    localparam func_t FN_CLEAR   = 3'd3;
    localparam func_t FN_DISPLAY = 3'd4;

    // Controller to datapath
    typedef struct packed {
        logic push;         // push the request word (dropped when full)
        logic pop;          // drop the top word
        logic clear;        // empty the stack
        logic pop_read;     // read the word under the old top
        logic top_from_rd;  // new top comes from read data
        logic list_start;   // begin listing at the bottom entry
        logic list_next;    // advance listing to the next entry
        logic list_load;    // load listed word from read data
        logic plain_load;   // load a single non-listing result
        logic ovf;          // overflow flag for plain_load
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic single;
        logic last;         // result register holds the final beat
    } status_t;

endpackage

/* sv/bls_if.sv */
interface bls_in_if import bls_pkg::*; ();
    logic  valid;
    logic  ready;
    func_t func;
    word_t push_value;

    modport source (output valid, output func, output push_value, input ready);
    modport sink   (input valid, input func, input push_value, output ready);
endinterface

interface bls_out_if import bls_pkg::*; ();
    logic    valid;
    logic    ready;
    word_t   top_value;
    logic    is_empty;
    wcount_t word_count;
    word_t   listed_word;
    logic    listed_valid;
    logic    last;
    logic    overflow;

    modport source (output valid, output top_value, output is_empty, output word_count,
                    output listed_word, output listed_valid, output last,
                    output overflow, input ready);
    modport sink   (input valid, input top_value, input is_empty, input word_count,
                    input listed_word, input listed_valid, input last,
                    input overflow, output ready);
endinterface

/* sv/bls_ctrl.sv */
module bls_ctrl import bls_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  func_t   func,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_POPW  = 4'b0010,
        S_LISTW = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = S_OUT;
                    unique case (func)
                        FN_PUSH:
                        begin
                            cmd.push       = 1'b1;
                            cmd.plain_load = 1'b1;
                            cmd.ovf        = status.full;
                        end
                        FN_POP:
                        begin
                            cmd.pop = ~status.empty;
                            if (!status.empty && !status.single)
                            begin
                                cmd.pop_read = 1'b1;
                                state_next   = S_POPW;
                            end
                            else
                            begin
                                cmd.plain_load = 1'b1;
                            end
                        end
                        FN_CLEAR:
                        begin
                            cmd.clear      = 1'b1;
                            cmd.plain_load = 1'b1;
                        end
                        FN_DISPLAY:
                        begin
                            if (status.empty)
                            begin
                                cmd.plain_load = 1'b1;
                            end
                            else
                            begin
                                cmd.list_start = 1'b1;
                                state_next     = S_LISTW;
                            end
                        end
                        default:
                        begin
                            cmd.plain_load = 1'b1;
                        end
                    endcase
                end
            end
            // read data holds the new top word
            S_POPW:
            begin
                cmd.top_from_rd = 1'b1;
                cmd.plain_load  = 1'b1;
                state_next      = S_OUT;
            end
            // read data holds the next listed word
            S_LISTW:
            begin
                cmd.list_load = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (status.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.list_next = 1'b1;
                        state_next    = S_LISTW;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* sv/bls_dp.sv */
module bls_dp import bls_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    cmd,
    input  word_t   push_value,
    output status_t status,
    output word_t   top_value,
    output logic    is_empty,
    output wcount_t word_count,
    output word_t   listed_word,
    output logic    listed_valid,
    output logic    last,
    output logic    overflow
);

    word_t mem [DEPTH];
    word_t rd_data_reg;

    cnt_t  count_reg, count_next;
    word_t top_reg, top_next;
    idx_t  idx_reg, idx_next;

    word_t listed_reg;
    logic  listed_valid_reg;
    logic  last_reg;
    logic  ovf_reg;

    idx_t  rd_addr;
    logic  rd_en;
    logic  full;
    logic  empty;
    logic  single;

    assign full   = (count_reg == cnt_t'(DEPTH));
    assign empty  = (count_reg == '0);
    assign single = (count_reg == cnt_t'(1));

    // Read address: word under the top, bottom entry, or next entry
    always_comb
    begin
        rd_addr = idx_t'(count_reg - cnt_t'(2));
        if (cmd.list_start)
        begin
            rd_addr = '0;
        end
        else if (cmd.list_next)
        begin
            rd_addr = idx_reg + idx_t'(1);
        end
    end

    assign rd_en = cmd.pop_read | cmd.list_start | cmd.list_next;

    // Storage: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.push && !full)
        begin
            mem[idx_t'(count_reg)] <= push_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Count, top word and listing index
    always_comb
    begin
        count_next = count_reg;
        top_next   = top_reg;
        idx_next   = idx_reg;
        if (cmd.push && !full)
        begin
            count_next = count_reg + cnt_t'(1);
            top_next   = push_value;
        end
        if (cmd.pop)
        begin
            count_next = count_reg - cnt_t'(1);
            if (single)
            begin
                top_next = '0;
            end
        end
        if (cmd.clear)
        begin
            count_next = '0;
            top_next   = '0;
        end
        if (cmd.top_from_rd)
        begin
            top_next = rd_data_reg;
        end
        if (cmd.list_start)
        begin
            idx_next = '0;
        end
        if (cmd.list_next)
        begin
            idx_next = idx_reg + idx_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            top_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            top_reg   <= top_next;
            idx_reg   <= idx_next;
        end
    end

    // Result register for the per-beat fields
    always_ff @(posedge clk)
    begin
        if (cmd.plain_load)
        begin
            listed_reg       <= '0;
            listed_valid_reg <= 1'b0;
            last_reg         <= 1'b1;
            ovf_reg          <= cmd.ovf;
        end
        else if (cmd.list_load)
        begin
            listed_reg       <= rd_data_reg;
            listed_valid_reg <= 1'b1;
            last_reg         <= (cnt_t'(idx_reg) + cnt_t'(1)) == count_reg;
            ovf_reg          <= 1'b0;
        end
    end

    assign status.empty  = empty;
    assign status.full   = full;
    assign status.single = single;
    assign status.last   = last_reg;

    assign top_value    = top_reg;
    assign is_empty     = empty;
    assign word_count   = WC_W'(count_reg);
    assign listed_word  = listed_reg;
    assign listed_valid = listed_valid_reg;
    assign last         = last_reg;
    assign overflow     = ovf_reg;

endmodule

/* sv/bounded_lifo_stack.sv */
// Channel  Dir  Beat contents
// -------  ---  -----------------------------------------------------------
// req      in   func, push_value
// rsp      out  top_value, is_empty, word_count, listed_word, listed_valid,
//               last, overflow
//
// One request at a time: req.ready is high only while no result is pending.
// Query, push, clear and a pop on or down to an empty stack go from accept straight to the beat;
// other pops wait in S_POPW while the new top is fetched through the registered read port.
// Display reads, then beats, each stored word in turn; an empty stack gives a single beat.
// rst_n clears the count and top word; stored words are not cleared.
// A stalled rsp holds the beat and the block; req is not taken meanwhile.
module bounded_lifo_stack import bls_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    bls_in_if.sink   req,
    bls_out_if.source rsp
);

    cmd_t    cmd;
    status_t status;

    bls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .func      (req.func),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    bls_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .push_value   (req.push_value),
        .status       (status),
        .top_value    (rsp.top_value),
        .is_empty     (rsp.is_empty),
        .word_count   (rsp.word_count),
        .listed_word  (rsp.listed_word),
        .listed_valid (rsp.listed_valid),
        .last         (rsp.last),
        .overflow     (rsp.overflow)
    );

    // Never take a request while a result beat is pending
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !rsp.valid)
        else $error("request taken while result pending");

    // Final beat of an item frees the request side
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.ready && rsp.last |=> req.ready)
        else $error("block did not return to idle after final beat");

    // Empty stack reports a zero top
    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.is_empty |-> rsp.top_value == '0)
        else $error("nonzero top on empty stack");

    // A dropped push only happens on a full stack
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.overflow |-> status.full)
        else $error("overflow flagged while not full");

endmodule
